>>> src/lru_pkg.sv
package lru_pkg;

    localparam int FRAMES  = 8;
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int AGE_W   = 3;
    localparam int OCC_W   = 4;
    localparam int FAULT_W = 32;
    localparam int LIMIT_W = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(FRAMES);

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_access;
    } t_access;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  frame_slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [OCC_W-1:0]   occupied;
        logic [FAULT_W-1:0] fault_total;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic look;
        logic commit;
    } t_lru_cmd;

endpackage

>>> src/lru_ctrl.sv
module lru_ctrl
    import lru_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_cfg_ready,
    output t_lru_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_cfg_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state     <= S_LOOK;
                        r_busy      <= 1'b1;
                        r_cfg_ready <= 1'b0;
                    end
                end
                S_LOOK: begin
                    r_state     <= S_UPD;
                    r_busy      <= 1'b0;
                    r_cfg_ready <= 1'b0;
                end
                S_UPD: begin
                    // next transaction may enter while this one commits
                    if (start) begin
                        r_state     <= S_LOOK;
                        r_busy      <= 1'b1;
                        r_cfg_ready <= 1'b0;
                    end else begin
                        r_state     <= S_IDLE;
                        r_busy      <= 1'b0;
                        r_cfg_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_busy      <= 1'b0;
                    r_cfg_ready <= 1'b1;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = r_cfg_ready;

    always_comb begin
        o_cmd.load   = start && !r_busy;
        o_cmd.look   = (r_state == S_LOOK);
        o_cmd.commit = (r_state == S_UPD);
    end

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than the lookup cycle");

    a_look_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_UPD))
        else $error("lookup not followed by update");

    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg_ready |-> (r_state == S_IDLE))
        else $error("config ready outside idle");

endmodule

>>> src/lru_dp.sv
module lru_dp
    import lru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lru_cmd           i_cmd,
    input  t_access            i_access,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output logic               o_done,
    output t_result            o_result
);

    logic [PAGE_W-1:0]  r_frame_page [FRAMES];
    logic [AGE_W-1:0]   r_age        [FRAMES];
    logic [OCC_W-1:0]   r_occ;
    logic [FAULT_W-1:0] r_fault;
    logic [LIMIT_W-1:0] r_limit;

    // transaction latched at accept
    logic [PAGE_W-1:0]  r_page;
    logic               r_last;

    // lookup results
    logic               r_hit;
    logic               r_fill;
    logic [SLOT_W-1:0]  r_slot;
    logic [OCC_W-1:0]   r_ref_age;
    logic [PAGE_W-1:0]  r_ev_page;

    logic               r_done;
    t_result            r_result;

    // ---------------- lookup ----------------
    logic               n_hit;
    logic               n_fill;
    logic [SLOT_W-1:0]  n_slot;
    logic [OCC_W-1:0]   n_ref_age;
    logic [SLOT_W-1:0]  hit_idx;
    logic [SLOT_W-1:0]  vic_idx;
    logic [LIMIT_W-1:0] eff_limit;
    logic [OCC_W-1:0]   oldest;

    always_comb begin
        hit_idx = '0;
        vic_idx = '0;
        n_hit   = 1'b0;
        oldest  = r_occ - OCC_W'(1);
        // lowest index wins
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (OCC_W'(i) < r_occ && r_frame_page[i] == r_page) begin
                n_hit   = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (OCC_W'(i) < r_occ && {1'b0, r_age[i]} == oldest) begin
                vic_idx = SLOT_W'(i);
            end
        end

        if (r_limit == '0) begin
            eff_limit = LIMIT_W'(1);
        end else if (r_limit > LIMIT_W'(FRAMES)) begin
            eff_limit = LIMIT_W'(FRAMES);
        end else begin
            eff_limit = r_limit;
        end

        n_fill = !n_hit && (r_occ < OCC_W'(eff_limit));

        if (n_hit) begin
            n_slot    = hit_idx;
            n_ref_age = {1'b0, r_age[hit_idx]};
        end else if (n_fill) begin
            n_slot    = r_occ[SLOT_W-1:0];
            n_ref_age = OCC_W'(FRAMES);   // every occupied frame ages
        end else begin
            n_slot    = vic_idx;
            n_ref_age = {1'b0, r_age[vic_idx]};
        end
    end

    // ---------------- update ----------------
    logic [AGE_W-1:0]   n_age [FRAMES];
    logic [OCC_W-1:0]   n_occ;
    logic [FAULT_W-1:0] n_fault;
    logic               ev_valid;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_age[i] = r_age[i];
            if (OCC_W'(i) < r_occ && {1'b0, r_age[i]} < r_ref_age) begin
                n_age[i] = r_age[i] + AGE_W'(1);
            end
            if (SLOT_W'(i) == r_slot) begin
                n_age[i] = '0;
            end
        end
        n_occ    = r_fill ? r_occ + OCC_W'(1) : r_occ;
        n_fault  = (!r_hit && r_fault != '1) ? r_fault + FAULT_W'(1) : r_fault;
        ev_valid = !r_hit && !r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_fault <= '0;
            r_limit <= LIMIT_RESET;
            r_done  <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_done <= i_cmd.commit;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_occ   <= '0;
                    r_fault <= '0;
                    for (int i = 0; i < FRAMES; i++) begin
                        r_age[i] <= '0;
                    end
                end else begin
                    r_occ   <= n_occ;
                    r_fault <= n_fault;
                    for (int i = 0; i < FRAMES; i++) begin
                        r_age[i] <= n_age[i];
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_access.page;
            r_last <= i_access.last_access;
        end
        if (i_cmd.look) begin
            r_hit     <= n_hit;
            r_fill    <= n_fill;
            r_slot    <= n_slot;
            r_ref_age <= n_ref_age;
            r_ev_page <= r_frame_page[vic_idx];
        end
        if (i_cmd.commit) begin
            if (!r_hit) begin
                r_frame_page[r_slot] <= r_page;
            end
            r_result.hit           <= r_hit;
            r_result.frame_slot    <= r_slot;
            r_result.evicted_valid <= ev_valid;
            r_result.evicted_page  <= ev_valid ? r_ev_page : '0;
            r_result.occupied      <= n_occ;
            r_result.fault_total   <= n_fault;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(FRAMES))
        else $error("occupancy beyond frame count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_result.hit && r_result.evicted_valid))
        else $error("hit reported together with eviction");

    a_done_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_done)
        else $error("commit without result strobe");

    a_fault_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit) |=> ($stable(r_fault) || r_fault == '0))
        else $error("fault count moved on a hit");

endmodule

>>> src/lru_page_replacement_top.sv
// o_done is registered: from the accepting edge, the lookup state comes first,
// then the update state, and o_done rises as the update state ends
// start is taken while the previous transaction commits, busy is high in the lookup cycle
// the result strobe o_done is shown for exactly one cycle and cannot be stalled by the receiver
// reset (synchronous, active low) empties all frames, zeroes ages and fault count
// and sets the frame limit to 8; no clearing pass is needed
module lru_page_replacement_top
    import lru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_access            i_access,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output logic               o_done,
    output t_result            o_result
);

    t_lru_cmd cmd;

    lru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    lru_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_access   (i_access),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
